// File: rtl/script_opcode_scanner_core_defines.svh
// Assertion macros for the script opcode scanner.
// Included by the top level; relies on nothing else.
`ifndef SCRIPT_OPCODE_SCANNER_CORE_DEFINES_SVH
`define SCRIPT_OPCODE_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sos_pkg.sv
// Shared types and constants for the script opcode scanner.
// No dependencies; every other file but the assertion macro header imports it.
package sos_pkg;

    localparam int unsigned MAX_SCRIPT_LEN = 16384;

    localparam logic [7:0] OPC_PUSHDATA1  = 8'h4c;
    localparam logic [7:0] OPC_PUSHDATA2  = 8'h4d;
    localparam logic [7:0] OPC_PUSHDATA4  = 8'h4e;
    localparam logic [7:0] OPC_16         = 8'h60;
    localparam logic [7:0] OPC_DUP        = 8'h76;
    localparam logic [7:0] OPC_EQUALVERIFY = 8'h88;
    localparam logic [7:0] OPC_HASH160    = 8'ha9;
    localparam logic [7:0] OPC_CHECKSIG   = 8'hac;
    localparam logic [7:0] OPC_CHECKSIGVERIFY = 8'had;
    localparam logic [7:0] OPC_CHECKMULTISIG  = 8'hae;
    localparam logic [7:0] OPC_CHECKMULTISIGVERIFY = 8'haf;

    localparam int unsigned SIGOP_W      = 19;
    localparam int unsigned BYTE_TOTAL_W = 17;
    localparam int unsigned LIMIT_W      = 16;
    localparam int unsigned LEN_W        = 32;
    localparam int unsigned WEIGHT_W     = 5;
    localparam int unsigned TPL_POS_W    = 3;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = 16'd200;
    localparam logic [LEN_W-1:0]    HASH_BYTES      = 32'd20;
    localparam logic [WEIGHT_W-1:0] MULTISIG_WEIGHT = 5'd20;
    localparam logic [WEIGHT_W-1:0] CHECKSIG_WEIGHT = 5'd1;
    localparam logic [TPL_POS_W-1:0] TPL_HASH_POS   = 3'd2;
    localparam logic [TPL_POS_W-1:0] TPL_DONE_POS   = 3'd5;

    localparam int unsigned SIGOP_CAP_RAW = 20 * MAX_SCRIPT_LEN;
    localparam int unsigned SIGOP_FIELD_MAX = (1 << SIGOP_W) - 1;
    localparam logic [SIGOP_W-1:0] SIGOP_CAP = (SIGOP_CAP_RAW > SIGOP_FIELD_MAX) ?
        SIGOP_W'(SIGOP_FIELD_MAX) : SIGOP_W'(SIGOP_CAP_RAW);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_LENGTH,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        OK_PUSH_DIRECT,
        OK_PUSHDATA,
        OK_PLAIN
    } t_op_kind;

    // Classification of a byte taken as an opcode.
    typedef struct packed {
        t_op_kind                  kind;
        logic [2:0]                len_bytes;
        logic [WEIGHT_W-1:0]       sig_weight;
        logic                      above_op16;
        logic [(1<<TPL_POS_W)-1:0] tpl_match;
    } t_cls;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       last_byte;
        logic       empty_script;
        t_cls       cls;
    } t_entry;

endpackage

// File: rtl/sos_channels.sv
// Handshake channels of the script opcode scanner: input bytes and results.
// Depends on sos_pkg for the field widths.
interface sos_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] script_byte;
    logic       last_byte;
    logic       empty_script;

    modport source (output valid, output script_byte, output last_byte,
                    output empty_script, input ready);
    modport sink   (input valid, input script_byte, input last_byte,
                    input empty_script, output ready);
endinterface

interface sos_out_if;
    import sos_pkg::*;
    logic               valid;
    logic               ready;
    logic [SIGOP_W-1:0] sigop_count;
    logic               push_only;
    logic               truncated;
    logic               address_template;

    modport source (output valid, output sigop_count, output push_only,
                    output truncated, output address_template, input ready);
    modport sink   (input valid, input sigop_count, input push_only,
                    input truncated, input address_template, output ready);
endinterface

// File: rtl/sos_front.sv
// Front end: accepts script bytes and classifies each one as an opcode.
// Depends on sos_pkg and sos_in_if.
module sos_front
    import sos_pkg::*;
(
    sos_in_if.sink   i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output t_entry   o_entry
);

    t_cls w_cls;

    always_comb begin
        w_cls            = '0;
        w_cls.kind       = OK_PLAIN;
        w_cls.len_bytes  = 3'd4;
        w_cls.above_op16 = (i_in.script_byte > OPC_16);
        if (i_in.script_byte < OPC_PUSHDATA1) begin
            w_cls.kind = OK_PUSH_DIRECT;
        end else if (i_in.script_byte <= OPC_PUSHDATA4) begin
            w_cls.kind = OK_PUSHDATA;
        end
        if (i_in.script_byte == OPC_PUSHDATA1) begin
            w_cls.len_bytes = 3'd1;
        end else if (i_in.script_byte == OPC_PUSHDATA2) begin
            w_cls.len_bytes = 3'd2;
        end
        if (i_in.script_byte == OPC_CHECKSIG || i_in.script_byte == OPC_CHECKSIGVERIFY) begin
            w_cls.sig_weight = CHECKSIG_WEIGHT;
        end else if (i_in.script_byte == OPC_CHECKMULTISIG ||
                     i_in.script_byte == OPC_CHECKMULTISIGVERIFY) begin
            w_cls.sig_weight = MULTISIG_WEIGHT;
        end
        // One bit per template position; the hash push position never matches an opcode.
        w_cls.tpl_match[0] = (i_in.script_byte == OPC_DUP);
        w_cls.tpl_match[1] = (i_in.script_byte == OPC_HASH160);
        w_cls.tpl_match[3] = (i_in.script_byte == OPC_EQUALVERIFY);
        w_cls.tpl_match[4] = (i_in.script_byte == OPC_CHECKSIG);
    end

    assign i_in.ready            = !i_q_full;
    assign o_push                = i_in.valid && !i_q_full;
    assign o_entry.script_byte   = i_in.script_byte;
    assign o_entry.last_byte     = i_in.last_byte;
    assign o_entry.empty_script  = i_in.empty_script;
    assign o_entry.cls           = w_cls;

endmodule

// File: rtl/sos_queue.sv
// Short register queue between the front end and the back end.
// Depends on sos_pkg.
module sos_queue
    import sos_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

endmodule

// File: rtl/sos_back.sv
// Back end: parse state machine, counters and the result register.
// Depends on sos_pkg and sos_out_if.
module sos_back
    import sos_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_entry              i_q_entry,
    input  logic [LIMIT_W-1:0]  i_limit,
    output logic                o_pop,
    sos_out_if.source           o_out
);

    t_phase                  r_phase, n_phase;
    logic [2:0]              r_len_left, n_len_left;
    logic [1:0]              r_len_idx, n_len_idx;
    logic [LEN_W-1:0]        r_data_left, n_data_left;
    logic [LEN_W-1:0]        r_push_len, n_push_len;
    logic [SIGOP_W-1:0]      r_sigops, n_sigops;
    logic [BYTE_TOTAL_W-1:0] r_bytes, n_bytes;
    logic                    r_only_push, n_only_push;
    logic [TPL_POS_W-1:0]    r_tpl_pos, n_tpl_pos;
    logic                    r_tpl_ok, n_tpl_ok;

    logic                    r_out_valid, n_out_valid;
    logic [SIGOP_W-1:0]      r_out_sigops, n_out_sigops;
    logic                    r_out_push_only, n_out_push_only;
    logic                    r_out_trunc, n_out_trunc;
    logic                    r_out_tpl, n_out_tpl;

    logic                    w_ends;
    logic                    w_start;
    logic [LEN_W-1:0]        w_start_len;
    logic [SIGOP_W:0]        w_sig_sum;
    logic                    w_trunc;

    assign w_ends = i_q_entry.last_byte || i_q_entry.empty_script;
    // A result-producing transaction needs the output register free or draining.
    assign o_pop  = i_q_valid && (!w_ends || !r_out_valid || o_out.ready);

    always_comb begin
        n_phase         = r_phase;
        n_len_left      = r_len_left;
        n_len_idx       = r_len_idx;
        n_data_left     = r_data_left;
        n_push_len      = r_push_len;
        n_sigops        = r_sigops;
        n_bytes         = r_bytes;
        n_only_push     = r_only_push;
        n_tpl_pos       = r_tpl_pos;
        n_tpl_ok        = r_tpl_ok;
        n_out_valid     = r_out_valid && !o_out.ready;
        n_out_sigops    = r_out_sigops;
        n_out_push_only = r_out_push_only;
        n_out_trunc     = r_out_trunc;
        n_out_tpl       = r_out_tpl;
        w_start         = 1'b0;
        w_start_len     = '0;
        w_sig_sum       = {1'b0, r_sigops} + (SIGOP_W + 1)'(i_q_entry.cls.sig_weight);
        w_trunc         = 1'b0;

        if (o_pop && !i_q_entry.empty_script) begin
            if (r_bytes != '1) begin
                n_bytes = r_bytes + 1'b1;
            end
            case (r_phase)
                PH_OPCODE: begin
                    case (i_q_entry.cls.kind)
                        OK_PUSH_DIRECT: begin
                            w_start     = 1'b1;
                            w_start_len = LEN_W'(i_q_entry.script_byte);
                        end
                        OK_PUSHDATA: begin
                            n_phase    = PH_LENGTH;
                            n_len_left = i_q_entry.cls.len_bytes;
                            n_len_idx  = '0;
                            n_push_len = '0;
                        end
                        OK_PLAIN: begin
                            if (i_q_entry.cls.above_op16) begin
                                n_only_push = 1'b0;
                            end
                            n_sigops = (w_sig_sum > (SIGOP_W + 1)'(SIGOP_CAP)) ?
                                SIGOP_CAP : w_sig_sum[SIGOP_W-1:0];
                            if (i_q_entry.cls.tpl_match[r_tpl_pos]) begin
                                n_tpl_pos = r_tpl_pos + 1'b1;
                            end else begin
                                n_tpl_ok = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                PH_LENGTH: begin
                    // Length bytes arrive least significant first.
                    n_push_len = r_push_len |
                        (LEN_W'(i_q_entry.script_byte) << {r_len_idx, 3'b000});
                    n_len_idx  = r_len_idx + 1'b1;
                    if (r_len_left != '0) begin
                        n_len_left = r_len_left - 1'b1;
                    end
                    if (n_len_left == '0) begin
                        w_start     = 1'b1;
                        w_start_len = n_push_len;
                    end
                end
                PH_DATA: begin
                    if (r_data_left != '0) begin
                        n_data_left = r_data_left - 1'b1;
                    end
                    if (n_data_left == '0) begin
                        n_phase = PH_OPCODE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_start) begin
            if (r_tpl_pos == TPL_HASH_POS) begin
                if (w_start_len != HASH_BYTES) begin
                    n_tpl_ok = 1'b0;
                end
                n_tpl_pos = r_tpl_pos + 1'b1;
            end else begin
                n_tpl_ok = 1'b0;
            end
            n_data_left = w_start_len;
            n_phase     = (w_start_len != '0) ? PH_DATA : PH_OPCODE;
        end

        if (o_pop && w_ends) begin
            w_trunc         = (n_phase != PH_OPCODE);
            n_out_valid     = 1'b1;
            n_out_sigops    = n_sigops;
            n_out_push_only = n_only_push && !w_trunc &&
                              (n_bytes <= BYTE_TOTAL_W'(i_limit));
            n_out_trunc     = w_trunc;
            n_out_tpl       = n_tpl_ok && (n_tpl_pos == TPL_DONE_POS) && !w_trunc;
            // The next script starts from a clean parse state.
            n_phase     = PH_OPCODE;
            n_len_left  = '0;
            n_len_idx   = '0;
            n_data_left = '0;
            n_push_len  = '0;
            n_sigops    = '0;
            n_bytes     = '0;
            n_only_push = 1'b1;
            n_tpl_pos   = '0;
            n_tpl_ok    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPCODE;
            r_len_left  <= '0;
            r_len_idx   <= '0;
            r_data_left <= '0;
            r_push_len  <= '0;
            r_sigops    <= '0;
            r_bytes     <= '0;
            r_only_push <= 1'b1;
            r_tpl_pos   <= '0;
            r_tpl_ok    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len_left  <= n_len_left;
            r_len_idx   <= n_len_idx;
            r_data_left <= n_data_left;
            r_push_len  <= n_push_len;
            r_sigops    <= n_sigops;
            r_bytes     <= n_bytes;
            r_only_push <= n_only_push;
            r_tpl_pos   <= n_tpl_pos;
            r_tpl_ok    <= n_tpl_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sigops    <= n_out_sigops;
        r_out_push_only <= n_out_push_only;
        r_out_trunc     <= n_out_trunc;
        r_out_tpl       <= n_out_tpl;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.sigop_count      = r_out_sigops;
    assign o_out.push_only        = r_out_push_only;
    assign o_out.truncated        = r_out_trunc;
    assign o_out.address_template = r_out_tpl;

endmodule

// File: rtl/script_opcode_scanner_core.sv
// Channel    | Dir | Payload                                          | Handshake
// i_in       | in  | script_byte, last_byte, empty_script             | valid/ready
// o_out      | out | sigop_count, push_only, truncated, address_tmpl  | valid/ready
// i_cfg_wr_* | in  | push_only_size_limit (16 bits)                   | write enable
//
// One script byte per cycle is sustained while no end-of-script byte waits. A byte is
// written into the queue when accepted and popped by the back end, whose pop of a
// script's final byte loads the output register; the result leaves from there.
// The back end's registered parse state update sets the rate.
// Reset is synchronous and active low; the size limit resets to 200.
// Bytes keep flowing while a result waits; only a script's final byte waits for the
// output register, and the input stalls once the two-entry queue is full behind it.
//
// Top level of the script opcode scanner. Depends on sos_pkg, the channel
// interfaces, sos_front, sos_queue, sos_back and the assertion macro header.
`include "script_opcode_scanner_core_defines.svh"

module script_opcode_scanner_core
    import sos_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    sos_in_if.sink             i_in,
    sos_out_if.source          o_out,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data
);

    logic [LIMIT_W-1:0] r_limit;
    logic               w_push;
    logic               w_pop;
    logic               w_q_full;
    logic               w_q_valid;
    t_entry             w_push_entry;
    t_entry             w_q_entry;
    logic               w_end_pop;
    logic               w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    sos_front u_front (
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    sos_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    sos_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_q_entry),
        .i_limit   (r_limit),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

    assign w_end_pop = w_pop && (w_q_entry.last_byte || w_q_entry.empty_script);
    assign w_busy    = o_out.valid || w_q_valid;

    `SOS_ASSERT_NOW(a_pop_needs_entry, i_clk, i_rst_n, w_pop, w_q_valid, "pop from empty queue")
    `SOS_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, w_end_pop, o_out.valid, "no result")
    `SOS_ASSERT_NEXT(a_reset_clears_out, i_clk, 1'b1, !i_rst_n, !w_busy, "reset leaves state")

endmodule

// File: verif/script_verdict_checker.sv
// Passive checker for the script opcode scanner. It watches the byte channel, the
// result channel and the size-limit port, predicts each verdict and compares it.
// Depends on sos_pkg and the channel interfaces in sos_channels.sv.
`timescale 1ns / 1ps

module script_verdict_checker
    import sos_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    sos_in_if                  i_bytes,
    sos_out_if                 i_verdicts,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_template_hits,
    output int                 o_truncations
);

    typedef struct packed {
        logic [SIGOP_W-1:0] sigop_count;
        logic               push_only;
        logic               truncated;
        logic               address_template;
    } t_verdict;

    t_verdict                expected_verdicts[$];
    logic [LIMIT_W-1:0]      size_limit;
    t_phase                  phase;
    logic [2:0]              len_left;
    logic [1:0]              len_idx;
    logic [LEN_W-1:0]        data_left;
    logic [LEN_W-1:0]        push_len;
    logic [SIGOP_W-1:0]      sigops;
    logic [BYTE_TOTAL_W-1:0] byte_cnt;
    logic                    only_pushes;
    logic [TPL_POS_W-1:0]    tpl_pos;
    logic                    tpl_ok;

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        o_fail_count++;
        $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    function automatic void clear_scan();
        phase       = PH_OPCODE;
        len_left    = '0;
        len_idx     = '0;
        data_left   = '0;
        push_len    = '0;
        sigops      = '0;
        byte_cnt    = '0;
        only_pushes = 1'b1;
        tpl_pos     = '0;
        tpl_ok      = 1'b1;
    endfunction

    function automatic void add_sigops(input logic [WEIGHT_W-1:0] weight);
        logic [SIGOP_W:0] sum;
        sum = {1'b0, sigops} + weight;
        sigops = (sum > {1'b0, SIGOP_CAP}) ? SIGOP_CAP : sum[SIGOP_W-1:0];
    endfunction

    // A push only fits the template in the hash slot, and only with 20 bytes.
    function automatic void begin_push(input logic [LEN_W-1:0] n);
        if (tpl_pos == TPL_HASH_POS) begin
            if (n != HASH_BYTES) tpl_ok = 1'b0;
            tpl_pos = TPL_HASH_POS + 3'd1;
        end else begin
            tpl_ok = 1'b0;
        end
        data_left = n;
        phase = (n != '0) ? PH_DATA : PH_OPCODE;
    endfunction

    function automatic void plain_op(input logic [7:0] op);
        logic [7:0] want;
        logic       slot;
        if (op > OPC_16) only_pushes = 1'b0;
        if (op == OPC_CHECKSIG || op == OPC_CHECKSIGVERIFY) begin
            add_sigops(CHECKSIG_WEIGHT);
        end else if (op == OPC_CHECKMULTISIG || op == OPC_CHECKMULTISIGVERIFY) begin
            add_sigops(MULTISIG_WEIGHT);
        end
        slot = 1'b1;
        case (tpl_pos)
            3'd0: want = OPC_DUP;
            3'd1: want = OPC_HASH160;
            3'd3: want = OPC_EQUALVERIFY;
            3'd4: want = OPC_CHECKSIG;
            default: begin
                want = '0;
                slot = 1'b0;
            end
        endcase
        if (slot && op == want) tpl_pos = tpl_pos + 3'd1;
        else tpl_ok = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        if (byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
        case (phase)
            PH_OPCODE: begin
                if (b < OPC_PUSHDATA1) begin
                    begin_push(LEN_W'(b));
                end else if (b <= OPC_PUSHDATA4) begin
                    phase    = PH_LENGTH;
                    len_left = (b == OPC_PUSHDATA1) ? 3'd1 : (b == OPC_PUSHDATA2) ? 3'd2 : 3'd4;
                    len_idx  = '0;
                    push_len = '0;
                end else begin
                    plain_op(b);
                end
            end
            PH_LENGTH: begin
                // Length bytes arrive least significant first.
                push_len = push_len | (LEN_W'(b) << (8 * len_idx));
                len_idx  = len_idx + 2'd1;
                if (len_left != '0) len_left = len_left - 3'd1;
                if (len_left == '0) begin_push(push_len);
            end
            default: begin
                if (data_left != '0) data_left = data_left - 1'b1;
                if (data_left == '0) phase = PH_OPCODE;
            end
        endcase
    endfunction

    function automatic t_verdict close_script();
        t_verdict v;
        logic     cut;
        cut                = (phase != PH_OPCODE);
        v.sigop_count      = sigops;
        v.push_only        = only_pushes && !cut && (byte_cnt <= BYTE_TOTAL_W'(size_limit));
        v.truncated        = cut;
        v.address_template = tpl_ok && (tpl_pos == TPL_DONE_POS) && !cut;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            expected_verdicts.delete();
            size_limit = LIMIT_RESET;
            clear_scan();
        end else begin
            if (i_verdicts.valid && i_verdicts.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with no script pending", 1, 0);
                end else begin
                    want = expected_verdicts.pop_front();
                    o_checked++;
                    if (want.address_template) o_template_hits++;
                    if (want.truncated) o_truncations++;
                    if (i_verdicts.sigop_count !== want.sigop_count)
                        report_mismatch("sigop_count", i_verdicts.sigop_count, want.sigop_count);
                    if (i_verdicts.push_only !== want.push_only)
                        report_mismatch("push_only", i_verdicts.push_only, want.push_only);
                    if (i_verdicts.truncated !== want.truncated)
                        report_mismatch("truncated", i_verdicts.truncated, want.truncated);
                    if (i_verdicts.address_template !== want.address_template)
                        report_mismatch("address_template", i_verdicts.address_template,
                                        want.address_template);
                end
            end
            if (i_cfg_wr_en) size_limit = i_cfg_wr_data;
            if (i_bytes.valid && i_bytes.ready) begin
                if (!i_bytes.empty_script) scan_byte(i_bytes.script_byte);
                if (i_bytes.empty_script || i_bytes.last_byte) begin
                    expected_verdicts = {expected_verdicts, close_script()};
                    clear_scan();
                end
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

// File: verif/script_opcode_scanner_core_test.sv
// Top of the script opcode scanner testbench: clock, reset, byte and result traffic,
// size-limit writes and the verdict. Depends on sos_pkg, sos_channels.sv, the
// scanner core and script_verdict_checker.
`timescale 1ns / 1ps

module script_opcode_scanner_core_test;
    import sos_pkg::*;

    localparam int ITEM_TARGET    = 1550;
    localparam int SEGMENT_ITEMS  = 150;
    localparam int MAX_GAP        = 16;
    localparam int LONG_HOLD      = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int BURST_SCRIPTS  = 40;
    localparam int HASH_LEN       = 20;

    typedef enum {PF_DIRECT, PF_LEN1, PF_LEN2, PF_LEN4} t_push_form;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LIMIT_W-1:0]  cfg_wr_data;
    bit                  tx_quiet;
    bit                  rx_quiet;
    bit                  hold_request;
    int                  bytes_sent;
    int                  scripts_sent;
    int                  limits_used;
    int                  idle_cycles;
    int                  fail_count;
    int                  pending;
    int                  checked;
    int                  template_hits;
    int                  truncations;
    logic [7:0]          script_q[$];
    logic [7:0]          sig_ops[4] = '{OPC_CHECKSIG, OPC_CHECKSIGVERIFY,
                                        OPC_CHECKMULTISIG, OPC_CHECKMULTISIGVERIFY};

    sos_in_if  in_ch ();
    sos_out_if out_ch ();

    script_opcode_scanner_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    script_verdict_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_bytes         (in_ch),
        .i_verdicts      (out_ch),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_template_hits (template_hits),
        .o_truncations   (truncations)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Ends the run when neither channel nor the register port has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("script_opcode_scanner_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stalls a random number of cycles before each transaction unless rx_quiet
    // is set, or holds off for a long stretch once when asked to.
    initial begin
        int hold;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            @(negedge clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    task automatic drive_byte(input logic [7:0] b, input logic last, input logic empty);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.script_byte  <= b;
        in_ch.last_byte    <= last;
        in_ch.empty_script <= empty;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_script(input bit end_by_empty);
        for (int i = 0; i < script_q.size(); i++)
            drive_byte(script_q[i], !end_by_empty && (i == script_q.size() - 1), 1'b0);
        if (end_by_empty)
            drive_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        scripts_sent++;
    endtask

    // Drops valid and waits until every pending verdict has come back.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_size_limit(input logic [LIMIT_W-1:0] limit);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        limits_used++;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        script_q = {script_q, b};
    endfunction

    function automatic void append_push(input int unsigned n);
        t_push_form form;
        form = t_push_form'((n < OPC_PUSHDATA1) ? $urandom_range(0, 3) : $urandom_range(1, 3));
        case (form)
            PF_DIRECT: add_byte(8'(n));
            PF_LEN1: begin
                add_byte(OPC_PUSHDATA1);
                add_byte(8'(n));
            end
            PF_LEN2: begin
                add_byte(OPC_PUSHDATA2);
                add_byte(8'(n));
                add_byte(8'(n >> 8));
            end
            default: begin
                add_byte(OPC_PUSHDATA4);
                add_byte(8'(n));
                add_byte(8'(n >> 8));
                add_byte(8'(n >> 16));
                add_byte(8'(n >> 24));
            end
        endcase
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void append_p2pkh(input int unsigned hash_len);
        add_byte(OPC_DUP);
        add_byte(OPC_HASH160);
        append_push(hash_len);
        add_byte(OPC_EQUALVERIFY);
        add_byte(OPC_CHECKSIG);
    endfunction

    task automatic build_random_script(output bit end_by_empty);
        int unsigned pick;
        int unsigned count;
        int unsigned sel;
        int unsigned n;
        logic [7:0]  op;
        script_q.delete();
        pick = $urandom_range(0, 99);
        end_by_empty = ($urandom_range(0, 9) == 0);
        if (pick < 30) begin
            append_p2pkh(HASH_LEN);
        end else if (pick < 45) begin
            // Template with one defect: wrong hash size, a replaced opcode, a trailing
            // opcode, a cut-off tail or a leading push.
            case ($urandom_range(0, 4))
                0: append_p2pkh($urandom_range(0, 1) ? HASH_LEN - 1 : HASH_LEN + 1);
                1: begin
                    append_p2pkh(HASH_LEN);
                    sel = $urandom_range(0, 3);
                    n = (sel < 2) ? sel : script_q.size() - 4 + sel;
                    script_q[n] = 8'($urandom_range(0, 255));
                end
                2: begin
                    append_p2pkh(HASH_LEN);
                    add_byte(8'($urandom_range(32'(OPC_16) + 1, 255)));
                end
                3: begin
                    append_p2pkh(HASH_LEN);
                    repeat ($urandom_range(1, script_q.size() - 1)) void'(script_q.pop_back());
                end
                default: begin
                    append_push($urandom_range(0, 4));
                    append_p2pkh(HASH_LEN);
                end
            endcase
        end else if (pick < 65) begin
            count = $urandom_range(1, 5);
            repeat (count) begin
                if ($urandom_range(0, 2) == 0)
                    add_byte(8'($urandom_range(32'(OPC_PUSHDATA4) + 1, 32'(OPC_16))));
                else
                    append_push($urandom_range(0, 12));
            end
        end else if (pick < 80) begin
            count = $urandom_range(1, 12);
            repeat (count) begin
                case ($urandom_range(0, 5))
                    0, 1, 2: add_byte(sig_ops[$urandom_range(0, 3)]);
                    3: add_byte(8'($urandom_range(32'(OPC_16) + 1, 255)));
                    4: append_push($urandom_range(0, 6));
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end else if (pick < 90) begin
            if ($urandom_range(0, 1)) append_push($urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0: begin
                    n = $urandom_range(2, 32'(OPC_PUSHDATA1) - 1);
                    add_byte(8'(n));
                    repeat ($urandom_range(0, n - 1))
                        add_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    // Cut inside the length field.
                    op = 8'($urandom_range(32'(OPC_PUSHDATA1), 32'(OPC_PUSHDATA4)));
                    n = (op == OPC_PUSHDATA1) ? 1 : (op == OPC_PUSHDATA2) ? 2 : 4;
                    add_byte(op);
                    repeat ($urandom_range(0, n - 1))
                        add_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    // Huge four-byte length followed by a few data bytes.
                    add_byte(OPC_PUSHDATA4);
                    repeat (3) add_byte(8'($urandom_range(0, 255)));
                    add_byte(8'($urandom_range(1, 255)));
                    repeat ($urandom_range(0, 6))
                        add_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 39) == 0) script_q.delete();
        if (script_q.size() == 0) end_by_empty = 1'b1;
    endtask

    initial begin
        bit          end_by_empty;
        int          seg;
        int          seg_start;
        logic [15:0] limit;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        in_ch.valid        = 1'b0;
        in_ch.script_byte  = '0;
        in_ch.last_byte    = 1'b0;
        in_ch.empty_script = 1'b0;
        tx_quiet           = 1'b0;
        rx_quiet           = 1'b0;
        hold_request       = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed scripts under the reset size limit.
        script_q.delete();
        send_script(1'b1);
        script_q = {OPC_CHECKSIG};
        send_script(1'b0);
        script_q = {OPC_CHECKMULTISIGVERIFY};
        send_script(1'b0);
        // The empty flag ends this script after its two opcodes.
        script_q = {OPC_CHECKSIGVERIFY, OPC_CHECKMULTISIG};
        send_script(1'b1);
        script_q = {OPC_16};
        send_script(1'b0);
        script_q = {OPC_DUP};
        send_script(1'b0);
        // A zero-length push, first as a direct length and then through PUSHDATA1.
        script_q = {8'h00};
        send_script(1'b0);
        script_q = {OPC_PUSHDATA1, 8'h00};
        send_script(1'b0);
        script_q = {OPC_PUSHDATA1};
        send_script(1'b0);
        script_q = {OPC_PUSHDATA2, 8'hff};
        send_script(1'b0);
        script_q = {OPC_PUSHDATA4, 8'hff, 8'hff, 8'hff, 8'hff, 8'h5a};
        send_script(1'b0);
        script_q = {8'hff};
        send_script(1'b1);

        // Long hold-off on the result side while single-byte scripts keep coming.
        wait_idle();
        tx_quiet = 1'b1;
        hold_request = 1'b1;
        repeat (BURST_SCRIPTS) begin
            script_q = {8'($urandom_range(0, 255))};
            send_script(1'b0);
        end

        seg = 0;
        while (bytes_sent < ITEM_TARGET) begin
            if (seg == 1) begin
                write_size_limit('0);
            end else if (seg == 2) begin
                write_size_limit('1);
            end else if (seg > 2) begin
                case ($urandom_range(0, 4))
                    0: limit = '0;
                    1: limit = '1;
                    2: limit = LIMIT_RESET;
                    3: limit = 16'($urandom_range(0, 40));
                    default: limit = 16'($urandom_range(0, 65535));
                endcase
                write_size_limit(limit);
            end
            tx_quiet = (seg % 4 == 1) || (seg % 4 == 3);
            rx_quiet = (seg % 4 == 2) || (seg % 4 == 3);
            seg_start = bytes_sent;
            while (bytes_sent - seg_start < SEGMENT_ITEMS && bytes_sent < ITEM_TARGET) begin
                build_random_script(end_by_empty);
                send_script(end_by_empty);
            end
            seg++;
        end

        wait_idle();
        $display("Drove %0d byte transactions in %0d scripts across %0d size-limit settings.",
                 bytes_sent, scripts_sent, limits_used + 1);
        $display("Checked %0d results: %0d template matches, %0d truncated scripts.",
                 checked, template_hits, truncations);
        if (fail_count == 0 && pending == 0) begin
            $display("script_opcode_scanner_core: match");
        end else begin
            $display("script_opcode_scanner_core: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sos_pkg.sv
rtl/sos_channels.sv
rtl/sos_front.sv
rtl/sos_queue.sv
rtl/sos_back.sv
rtl/script_opcode_scanner_core.sv
verif/script_verdict_checker.sv
verif/script_opcode_scanner_core_test.sv
